@@ src/bti_pkg.sv @@
// Shared constants and types for the bilinear table interpolator.
package bti_pkg;

  localparam int DefMaxXPoints = 16;
  localparam int DefMaxYPoints = 16;

  localparam logic [1:0] ModeWrX   = 2'd0;
  localparam logic [1:0] ModeWrY   = 2'd1;
  localparam logic [1:0] ModeWrZ   = 2'd2;
  localparam logic [1:0] ModeQuery = 2'd3;

  localparam logic CfgXCount = 1'b0;
  localparam logic CfgYCount = 1'b1;

  // One accepted item as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  index;
    logic [31:0] value;
    logic [31:0] qx;
    logic [31:0] qy;
  } bti_item_t;

  // Saturate a signed value of up to 66 bits to signed 32 bits.
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ src/bti_queue.sv @@
// Small item queue between the front end and the back end.
module bti_queue
  import bti_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bti_item_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output bti_item_t pop_data
);

  localparam int Depth = 4;

  bti_item_t  mem [Depth];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full     = (count == 3'(Depth));
  assign empty    = (count == 3'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(push && !full) - 3'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(Depth)) else $error("queue count overflow");
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !push) |=> count == $past(count) - 3'd1)
    else $error("queue pop miscount");
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> count == $past(count) + 3'd1)
    else $error("queue push miscount");
`endif

endmodule

@@ src/bti_div.sv @@
// Restoring signed divider: 49-bit dividend by 33-bit divisor, one bit a cycle.
module bti_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [48:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [48:0] quo
);

  logic [48:0] n_mag;
  logic [32:0] d_mag;
  logic [33:0] rem;
  logic [48:0] q;
  logic [5:0]  cnt;
  logic        neg;
  logic        run;
  logic [33:0] trial;

  assign trial = {rem[32:0], n_mag[48]} - {1'b0, d_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        n_mag <= num[48] ? 49'(-num) : num;
        d_mag <= den[32] ? 33'(-den) : den;
        neg   <= num[48] ^ den[32];
        rem   <= '0;
        cnt   <= 6'd49;
      end else if (run) begin
        n_mag <= {n_mag[47:0], 1'b0};
        if (!trial[33]) begin
          rem <= trial;
          q   <= {q[47:0], 1'b1};
        end else begin
          rem <= {rem[32:0], n_mag[48]};
          q   <= {q[47:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? 49'(-q) : q;

endmodule

@@ src/bti_back.sv @@
// Back end: table stores, clamp, search and three interpolation segments.
module bti_back
  import bti_pkg::*;
#(
  parameter int MAX_X_POINTS = DefMaxXPoints,
  parameter int MAX_Y_POINTS = DefMaxYPoints
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  bti_item_t   item,
  output logic        pop,
  input  logic [4:0]  x_count,
  input  logic [4:0]  y_count,
  output logic        idle,
  output logic        result_strobe,
  output logic [31:0] result_value,
  output logic        out_of_range
);

  localparam int XW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int YW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int GD = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GW = $clog2(GD);

  typedef enum logic [3:0] {
    S_IDLE, S_RDLO, S_RDHI, S_CLAMP, S_SRCH, S_RDG0, S_RDG1, S_RDG2, S_RDG3,
    S_SEG, S_DIV, S_MUL, S_FIN
  } state_t;

  state_t state;

  logic [31:0] xmem [MAX_X_POINTS];
  logic [31:0] ymem [MAX_Y_POINTS];
  logic [31:0] zmem [GD];
  logic [31:0] xrd, yrd, zrd;
  logic [XW-1:0] xra;
  logic [YW-1:0] yra;
  logic [GW-1:0] zra;

  logic signed [31:0] qx, qy, x0, x1, y0, y1, z00, z10, z01, z11, r0, r1;
  logic [XW-1:0] ix, nxm1;
  logic [YW-1:0] iy, nym1;
  logic oor;
  logic [1:0] seg;
  logic [1:0] step;

  logic signed [31:0] sz0, sz1, sa0, sa1, sq, slope;
  logic signed [63:0] prod;
  logic               dgo, ddone;
  logic signed [48:0] dquo;

  // Writes of the three stores happen straight off the queue head.
  logic wr;
  assign wr = (state == S_IDLE) && !empty && (item.mode != ModeQuery);
  assign pop = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (wr && item.mode == ModeWrX && 32'(item.index) < 32'(MAX_X_POINTS)) begin
      xmem[item.index[XW-1:0]] <= item.value;
    end
    if (wr && item.mode == ModeWrY && 32'(item.index) < 32'(MAX_Y_POINTS)) begin
      ymem[item.index[YW-1:0]] <= item.value;
    end
    if (wr && item.mode == ModeWrZ && 32'(item.index) < 32'(GD)) begin
      zmem[item.index[GW-1:0]] <= item.value;
    end
    xrd <= xmem[xra];
    yrd <= ymem[yra];
    zrd <= zmem[zra];
  end

  logic [XW:0] nx_e;
  logic [YW:0] ny_e;
  always_comb begin
    if (x_count < 5'd2) nx_e = (XW+1)'(2);
    else if (32'(x_count) > 32'(MAX_X_POINTS)) nx_e = (XW+1)'(MAX_X_POINTS);
    else nx_e = (XW+1)'(x_count);
    if (y_count < 5'd2) ny_e = (YW+1)'(2);
    else if (32'(y_count) > 32'(MAX_Y_POINTS)) ny_e = (YW+1)'(MAX_Y_POINTS);
    else ny_e = (YW+1)'(y_count);
  end

  logic signed [32:0] dspan;
  logic signed [48:0] dnum;
  assign dspan = 33'(sa1) - 33'(sa0);
  assign dnum  = (49'(sz1) - 49'(sz0)) <<< 16;
  assign dgo   = (state == S_SEG) && (dspan != 33'sd0);

  bti_div u_div (
    .clk (clk), .rst (rst), .go (dgo), .num (dnum), .den (dspan),
    .done (ddone), .quo (dquo)
  );

  logic signed [32:0] qd;
  logic signed [65:0] sum;
  assign qd  = 33'(sq) - 33'(sa0);
  assign sum = 66'(sz0) + 66'(prod >>> 16);

  always_comb begin
    unique case (seg)
      2'd0: begin sz0 = z00; sz1 = z10; sa0 = x0; sa1 = x1; sq = qx; end
      2'd1: begin sz0 = z01; sz1 = z11; sa0 = x0; sa1 = x1; sq = qx; end
      default: begin sz0 = r0; sz1 = r1; sa0 = y0; sa1 = y1; sq = qy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty && item.mode == ModeQuery) begin
            qx    <= item.qx;
            qy    <= item.qy;
            nxm1  <= XW'(nx_e - 1'b1);
            nym1  <= YW'(ny_e - 1'b1);
            xra   <= '0;
            yra   <= '0;
            state <= S_RDLO;
          end
        end
        S_RDLO: begin
          xra   <= nxm1;
          yra   <= nym1;
          state <= S_RDHI;
        end
        S_RDHI: begin
          x0    <= xrd;
          y0    <= yrd;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          // x0/y0 hold the first breakpoints, xrd/yrd the last ones in use.
          oor <= 1'b0;
          if (qx < x0) begin qx <= x0; oor <= 1'b1; end
          else if (qx > $signed(xrd)) begin qx <= xrd; oor <= 1'b1; end
          if (qy < y0) begin qy <= y0; oor <= 1'b1; end
          else if (qy > $signed(yrd)) begin qy <= yrd; oor <= 1'b1; end
          ix    <= nxm1 - 1'b1;
          iy    <= nym1 - 1'b1;
          xra   <= nxm1 - 1'b1;
          yra   <= nym1 - 1'b1;
          step  <= 2'd0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          // Downward search: step 0 waits for the registered read, step 1 compares.
          if (step == 2'd0) begin
            step <= 2'd1;
          end else begin
            logic xok, yok;
            xok = (ix == '0) || (qx >= $signed(xrd));
            yok = (iy == '0) || (qy >= $signed(yrd));
            if (!xok) begin ix <= ix - 1'b1; xra <= ix - 1'b1; end
            if (!yok) begin iy <= iy - 1'b1; yra <= iy - 1'b1; end
            step <= 2'd0;
            if (xok && yok) begin
              xra   <= ix;
              yra   <= iy;
              zra   <= GW'(32'(ix) * MAX_Y_POINTS + 32'(iy));
              state <= S_RDG0;
            end
          end
        end
        S_RDG0: begin
          xra   <= ix + 1'b1;
          yra   <= iy + 1'b1;
          zra   <= GW'((32'(ix) + 1) * MAX_Y_POINTS + 32'(iy));
          state <= S_RDG1;
        end
        S_RDG1: begin
          x0    <= xrd;
          y0    <= yrd;
          z00   <= zrd;
          zra   <= GW'(32'(ix) * MAX_Y_POINTS + 32'(iy) + 1);
          state <= S_RDG2;
        end
        S_RDG2: begin
          x1    <= xrd;
          y1    <= yrd;
          z10   <= zrd;
          zra   <= GW'((32'(ix) + 1) * MAX_Y_POINTS + 32'(iy) + 1);
          state <= S_RDG3;
        end
        S_RDG3: begin
          z01   <= zrd;
          seg   <= 2'd0;
          state <= S_SEG;
        end
        S_SEG: begin
          if (seg == 2'd0) z11 <= zrd;
          if (dspan == 33'sd0) begin
            slope <= '0;
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            slope <= sat32(66'(dquo));
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 64'(slope) * 64'(qd);
          state <= S_FIN;
        end
        S_FIN: begin
          unique case (seg)
            2'd0: begin r0 <= sat32(sum); seg <= 2'd1; state <= S_SEG; end
            2'd1: begin r1 <= sat32(sum); seg <= 2'd2; state <= S_SEG; end
            default: begin
              result_value  <= sat32(sum);
              out_of_range  <= oor;
              result_strobe <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);

`ifndef SYNTHESIS
  a_strobe_from_fin: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state) == S_FIN) else $error("stray result strobe");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    ddone |-> state == S_DIV) else $error("divider done outside wait");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE) else $error("pop while busy");
`endif

endmodule

@@ src/bti_front.sv @@
// Front end: command capture, configuration registers and queue push.
module bti_front
  import bti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [7:0]  write_index,
  input  logic [31:0] write_value,
  input  logic [31:0] query_x,
  input  logic [31:0] query_y,
  input  logic        full,
  output logic        busy,
  output logic        push,
  output bti_item_t   push_data,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        cfg_ready,
  output logic [4:0]  x_count,
  output logic [4:0]  y_count
);

  assign busy      = full;
  assign push      = start && !full;
  assign cfg_ready = 1'b1;
  assign push_data = '{mode: mode, index: write_index, value: write_value,
                       qx: query_x, qy: query_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= 5'd2;
      y_count <= 5'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgXCount: x_count <= cfg_data;
        CfgYCount: y_count <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/bilinear_table_interpolator.sv @@
// Top level of the bilinear table interpolator.
//
//  Channel   Signals                                     Transfer
//  command   start, busy, mode, write_index, ...         start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//  result    result_strobe, result_value, out_of_range   one cycle per strobe
//
// Writes are taken straight off the queue head while the back end is idle. A query
// holds the back end for reads and clamping, a downward breakpoint search and three
// segments, each set by the bit-serial divider; a zero span skips the division.
// A four-entry command queue lets commands arrive while a query is worked.
// Reset is synchronous; it clears counts to 2 and empties the queue.
// The receiver cannot stall; busy only reflects a full queue.
module bilinear_table_interpolator
  import bti_pkg::*;
#(
  parameter int MAX_X_POINTS = DefMaxXPoints,
  parameter int MAX_Y_POINTS = DefMaxYPoints
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  write_index,
  input  logic [31:0] write_value,
  input  logic [31:0] query_x,
  input  logic [31:0] query_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        result_strobe,
  output logic [31:0] result_value,
  output logic        out_of_range
);

  logic      full, push, empty, pop, idle;
  bti_item_t push_data, head;
  logic [4:0] x_count, y_count;

  bti_front u_front (
    .clk, .rst, .start, .mode, .write_index, .write_value, .query_x,
    .query_y, .full, .busy, .push, .push_data, .cfg_valid, .cfg_index,
    .cfg_data, .cfg_ready, .x_count, .y_count
  );

  bti_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .pop_data (head)
  );

  bti_back #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_back (
    .clk, .rst, .empty, .item (head), .pop, .x_count, .y_count, .idle,
    .result_strobe, .result_value, .out_of_range
  );

`ifndef SYNTHESIS
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push) else $error("push while busy");
  a_idle_strobe: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> idle) else $error("strobe while back end busy");
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("config port stalled");
`endif

endmodule
